// ===== sv/rnp_pkg.sv =====
// Package for the RTTTL note parser: payload structs, parser phases, command
// format between front and back, character codes and the tone table.
// Depends on nothing; every other file of the block imports it.
package rnp_pkg;

  localparam int unsigned DigitWidthDef = 16;
  localparam int unsigned DigitWidthMax = 32;
  localparam int unsigned WholeW        = 18;
  localparam int unsigned DurW          = 19;
  localparam int unsigned FreqW         = 12;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [WholeW-1:0] WholeReset  = 18'd3808;
  localparam logic [WholeW-1:0] MsPerMinute = 18'd60000;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSharp = 8'h23;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharThree = 8'h33;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharB     = 8'h62;
  localparam logic [7:0] CharC     = 8'h63;
  localparam logic [7:0] CharD     = 8'h64;
  localparam logic [7:0] CharE     = 8'h65;
  localparam logic [7:0] CharF     = 8'h66;
  localparam logic [7:0] CharG     = 8'h67;
  localparam logic [7:0] CharO     = 8'h6F;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
    logic       abort;
  } in_item_t;

  typedef struct packed {
    logic [FreqW-1:0] frequency_hz;
    logic [DurW-1:0]  duration_ms;
    logic             last_of_run;
    logic             tune_end;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_NAME,
    PH_KEY_D,
    PH_D_VAL,
    PH_KEY_O,
    PH_O_VAL,
    PH_KEY_B,
    PH_B_VAL,
    PH_N_DUR,
    PH_N_DUR_DIG,
    PH_N_SHARP,
    PH_N_DOT,
    PH_N_OCT,
    PH_N_COMMA,
    PH_N_DONE
  } phase_e;

  typedef enum logic [1:0] {
    CMD_NOTE,
    CMD_TEMPO,
    CMD_RESTART
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_HOLD
  } back_state_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [3:0]               semitone;
    logic [3:0]               octave;
    logic                     dotted;
    logic [DigitWidthMax-1:0] value;
    logic                     last_of_run;
    logic                     tune_end;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic logic [3:0] semitone_of(input logic [7:0] c);
    logic [3:0] s;
    case (c)
      CharC:   s = 4'd1;
      CharD:   s = 4'd3;
      CharE:   s = 4'd5;
      CharF:   s = 4'd6;
      CharG:   s = 4'd8;
      CharA:   s = 4'd10;
      CharB:   s = 4'd12;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [FreqW-1:0] tone_lookup(input logic [5:0] idx);
    logic [FreqW-1:0] f;
    case (idx)
      6'd1:  f = 12'd262;  6'd2:  f = 12'd277;  6'd3:  f = 12'd294;  6'd4:  f = 12'd311;
      6'd5:  f = 12'd330;  6'd6:  f = 12'd349;  6'd7:  f = 12'd370;  6'd8:  f = 12'd392;
      6'd9:  f = 12'd415;  6'd10: f = 12'd440;  6'd11: f = 12'd466;  6'd12: f = 12'd494;
      6'd13: f = 12'd523;  6'd14: f = 12'd554;  6'd15: f = 12'd587;  6'd16: f = 12'd622;
      6'd17: f = 12'd659;  6'd18: f = 12'd698;  6'd19: f = 12'd740;  6'd20: f = 12'd784;
      6'd21: f = 12'd831;  6'd22: f = 12'd880;  6'd23: f = 12'd932;  6'd24: f = 12'd988;
      6'd25: f = 12'd1047; 6'd26: f = 12'd1109; 6'd27: f = 12'd1175; 6'd28: f = 12'd1245;
      6'd29: f = 12'd1319; 6'd30: f = 12'd1397; 6'd31: f = 12'd1480; 6'd32: f = 12'd1568;
      6'd33: f = 12'd1661; 6'd34: f = 12'd1760; 6'd35: f = 12'd1865; 6'd36: f = 12'd1976;
      6'd37: f = 12'd2093; 6'd38: f = 12'd2217; 6'd39: f = 12'd2349; 6'd40: f = 12'd2489;
      6'd41: f = 12'd2637; 6'd42: f = 12'd2794; 6'd43: f = 12'd2960; 6'd44: f = 12'd3136;
      6'd45: f = 12'd3322; 6'd46: f = 12'd3520; 6'd47: f = 12'd3729; 6'd48: f = 12'd3951;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/rnp_front.sv =====
// Front end of the RTTTL note parser: header and note token parsing, and a
// two-slot command buffer that feeds the command queue.
// Depends on rnp_pkg.
module rnp_front #(
  parameter int unsigned DIGIT_WIDTH = rnp_pkg::DigitWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rnp_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output rnp_pkg::cmd_t     cmd_o
);
  import rnp_pkg::*;

  localparam logic [DIGIT_WIDTH-1:0] DigitMax = '1;
  localparam int unsigned AccW = DIGIT_WIDTH + 4;

  phase_e                 phase_q, phase_d, stage;
  logic [1:0]             skip_q, skip_d;
  logic [7:0]             dlen_q, dlen_d;
  logic [2:0]             doct_q, doct_d;
  logic [DIGIT_WIDTH-1:0] digit_q, digit_d;
  logic [3:0]             psemi_q, psemi_d;
  logic                   pdot_q, pdot_d;
  logic [3:0]             poct_q, poct_d;
  logic [DIGIT_WIDTH-1:0] pdiv_q, pdiv_d;

  cmd_t       slot_q [2];
  cmd_t       slot_d [2];
  logic [1:0] slot_v_q, slot_v_d;

  logic       accept;
  logic [7:0] c;
  logic       handled, do_dur, emit_a, emit_b, tempo, restart;
  cmd_t       cmd_a, cmd_b, cmd_first, cmd_second;
  logic       first_v, second_v;

  function automatic logic [DIGIT_WIDTH-1:0] digit_push(input logic [DIGIT_WIDTH-1:0] v,
                                                        input logic [7:0] ch);
    logic [AccW-1:0] r;
    r = (AccW'(v) << 3) + (AccW'(v) << 1) + AccW'(ch[3:0]);
    if (r > AccW'(DigitMax)) begin
      return DigitMax;
    end
    return r[DIGIT_WIDTH-1:0];
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign c           = in_item_i.char_code;
  assign in_ready_o  = !slot_v_q[0];
  assign cmd_valid_o = slot_v_q[0];
  assign cmd_o       = slot_q[0];

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    dlen_d  = dlen_q;
    doct_d  = doct_q;
    digit_d = digit_q;
    psemi_d = psemi_q;
    pdot_d  = pdot_q;
    poct_d  = poct_q;
    pdiv_d  = pdiv_q;
    stage   = phase_q;
    handled = 1'b0;
    do_dur  = 1'b0;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    tempo   = 1'b0;
    restart = 1'b0;

    cmd_a             = '0;
    cmd_a.kind        = CMD_NOTE;
    cmd_a.semitone    = psemi_q;
    cmd_a.octave      = poct_q;
    cmd_a.dotted      = pdot_q;
    cmd_a.value       = DigitWidthMax'(pdiv_q);

    if (in_item_i.abort) begin
      restart = 1'b1;
    end else begin
      case (phase_q)
        PH_NAME: begin
          if (c == CharColon) begin
            phase_d = PH_KEY_D;
          end
        end
        PH_KEY_D, PH_KEY_O, PH_KEY_B: begin
          if (phase_q == PH_KEY_D && c == CharD) begin
            phase_d = PH_D_VAL;
            skip_d  = 2'd1;
            digit_d = '0;
          end else if (phase_q != PH_KEY_B && c == CharO) begin
            phase_d = PH_O_VAL;
            skip_d  = 2'd0;
          end else if (c == CharB) begin
            phase_d = PH_B_VAL;
            skip_d  = 2'd1;
            digit_d = '0;
          end else begin
            digit_d = '0;
            phase_d = PH_N_DUR;
            do_dur  = 1'b1;
          end
        end
        PH_D_VAL: begin
          if (skip_q != 2'd0) begin
            skip_d = 2'd0;
          end else if (is_digit(c)) begin
            digit_d = digit_push(digit_q, c);
          end else begin
            if (digit_q != '0) begin
              dlen_d = (digit_q > DIGIT_WIDTH'(8'hFF)) ? 8'hFF : digit_q[7:0];
            end
            phase_d = PH_KEY_O;
          end
        end
        PH_O_VAL: begin
          case (skip_q)
            2'd0: skip_d = 2'd1;
            2'd1: begin
              if (c inside {[CharThree:CharSeven]}) begin
                doct_d = c[2:0];
              end
              skip_d = 2'd2;
            end
            default: begin
              skip_d  = 2'd0;
              phase_d = PH_KEY_B;
            end
          endcase
        end
        PH_B_VAL: begin
          if (skip_q != 2'd0) begin
            skip_d = 2'd0;
          end else if (is_digit(c)) begin
            digit_d = digit_push(digit_q, c);
          end else begin
            tempo   = (digit_q != '0);
            digit_d = '0;
            phase_d = PH_N_DUR;
          end
        end
        PH_N_DUR, PH_N_DUR_DIG: begin
          do_dur = 1'b1;
        end
        default: begin
          if (stage == PH_N_SHARP) begin
            if (c == CharSharp) begin
              psemi_d = psemi_q + 4'd1;
              phase_d = PH_N_DOT;
              handled = 1'b1;
            end else begin
              stage = PH_N_DOT;
            end
          end
          if (!handled && stage == PH_N_DOT) begin
            if (c == CharDot) begin
              pdot_d  = 1'b1;
              phase_d = PH_N_OCT;
              handled = 1'b1;
            end else begin
              stage = PH_N_OCT;
            end
          end
          if (!handled && stage == PH_N_OCT) begin
            if (is_digit(c)) begin
              poct_d  = c[3:0];
              phase_d = PH_N_COMMA;
              handled = 1'b1;
            end else begin
              stage = PH_N_COMMA;
            end
          end
          if (!handled && stage == PH_N_COMMA) begin
            if (c == CharComma) begin
              phase_d = PH_N_DONE;
              handled = 1'b1;
            end
          end
          if (!handled) begin
            emit_a  = 1'b1;
            digit_d = '0;
            phase_d = PH_N_DUR;
            do_dur  = 1'b1;
          end
        end
      endcase

      if (do_dur) begin
        if (is_digit(c)) begin
          digit_d = digit_push(digit_d, c);
          phase_d = PH_N_DUR_DIG;
        end else begin
          psemi_d = semitone_of(c);
          pdiv_d  = (digit_d != '0) ? digit_d : DIGIT_WIDTH'(dlen_d);
          pdot_d  = 1'b0;
          poct_d  = {1'b0, doct_d};
          phase_d = PH_N_SHARP;
        end
      end

      if (in_item_i.end_of_text) begin
        if (phase_d == PH_N_DUR_DIG) begin
          psemi_d = 4'd0;
          pdiv_d  = (digit_d != '0) ? digit_d : DIGIT_WIDTH'(dlen_d);
          pdot_d  = 1'b0;
          poct_d  = {1'b0, doct_d};
          phase_d = PH_N_DONE;
        end
        emit_b  = (phase_d inside {[PH_N_SHARP:PH_N_DONE]});
        restart = 1'b1;
      end
    end

    cmd_a.last_of_run = !emit_b;
    cmd_a.tune_end    = 1'b0;

    cmd_b             = '0;
    cmd_b.kind        = emit_b ? CMD_NOTE : CMD_RESTART;
    cmd_b.semitone    = psemi_d;
    cmd_b.octave      = poct_d;
    cmd_b.dotted      = pdot_d;
    cmd_b.value       = DigitWidthMax'(pdiv_d);
    cmd_b.last_of_run = 1'b1;
    cmd_b.tune_end    = 1'b1;

    cmd_first = cmd_a;
    if (!emit_a) begin
      cmd_first       = '0;
      cmd_first.kind  = CMD_TEMPO;
      cmd_first.value = DigitWidthMax'(digit_q);
    end
    cmd_second = cmd_b;
    first_v    = emit_a || tempo;
    second_v   = emit_b || restart;

    if (restart) begin
      phase_d = PH_NAME;
      skip_d  = 2'd0;
      dlen_d  = 8'd4;
      doct_d  = 3'd6;
      digit_d = '0;
      psemi_d = 4'd0;
      pdot_d  = 1'b0;
      poct_d  = 4'd0;
      pdiv_d  = '0;
    end
  end

  always_comb begin
    slot_d   = slot_q;
    slot_v_d = slot_v_q;
    if (accept) begin
      slot_d[0]   = first_v ? cmd_first : cmd_second;
      slot_d[1]   = cmd_second;
      slot_v_d[0] = first_v || second_v;
      slot_v_d[1] = first_v && second_v;
    end else if (cmd_valid_o && cmd_ready_i) begin
      slot_d[0] = slot_q[1];
      slot_v_d  = {1'b0, slot_v_q[1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NAME;
      skip_q   <= 2'd0;
      dlen_q   <= 8'd4;
      doct_q   <= 3'd6;
      digit_q  <= '0;
      psemi_q  <= 4'd0;
      pdot_q   <= 1'b0;
      poct_q   <= 4'd0;
      pdiv_q   <= '0;
      slot_v_q <= 2'b00;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        skip_q  <= skip_d;
        dlen_q  <= dlen_d;
        doct_q  <= doct_d;
        digit_q <= digit_d;
        psemi_q <= psemi_d;
        pdot_q  <= pdot_d;
        poct_q  <= poct_d;
        pdiv_q  <= pdiv_d;
      end
      slot_v_q <= slot_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // The buffer is always compacted toward the first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !slot_v_q[1])
    else $error("front: second command slot holds a command while input is open");

endmodule

// ===== sv/rnp_fifo.sv =====
// Command queue between the front end and the back end of the note parser.
// Small register file with read and write pointers. Depends on rnp_pkg.
module rnp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rnp_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rnp_pkg::cmd_t pop_cmd_o
);
  import rnp_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QueueDepth))
    else $error("fifo: occupancy exceeds the queue depth");

endmodule

// ===== sv/rnp_div.sv =====
// Restoring divider for the note parser back end, one quotient bit per cycle.
// Divides an 18-bit dividend by a 32-bit divisor; a zero divisor acts as one.
// Depends on rnp_pkg.
module rnp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rnp_pkg::WholeW-1:0]        dividend_i,
  input  logic [rnp_pkg::DigitWidthMax-1:0] divisor_i,
  output logic                              done_o,
  output logic [rnp_pkg::WholeW-1:0]        quotient_o
);
  import rnp_pkg::*;

  localparam int unsigned CntW = $clog2(WholeW + 1);

  logic                     active_q, done_q;
  logic [CntW-1:0]          cnt_q;
  logic [WholeW-1:0]        quo_q, rem_q;
  logic [DigitWidthMax-1:0] den_q;
  logic [WholeW:0]          trial;
  logic [DigitWidthMax-1:0] trial_ext, diff;
  logic                     fits;

  assign trial      = {rem_q, quo_q[WholeW-1]};
  assign trial_ext  = DigitWidthMax'(trial);
  assign fits       = (trial_ext >= den_q);
  assign diff       = trial_ext - den_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= CntW'(WholeW);
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= (divisor_i == '0) ? DigitWidthMax'(1) : divisor_i;
    end else if (active_q) begin
      rem_q <= fits ? diff[WholeW-1:0] : trial[WholeW-1:0];
      quo_q <= {quo_q[WholeW-2:0], fits};
    end
  end

endmodule

// ===== sv/rnp_back.sv =====
// Back end of the note parser: executes queued commands, keeps the whole-note
// time and the mute register, and drives the output register.
// Depends on rnp_pkg and rnp_div.
module rnp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_mute_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  rnp_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rnp_pkg::out_item_t out_item_o
);
  import rnp_pkg::*;

  back_state_e       state_q, state_d;
  cmd_t              cur_q;
  logic [WholeW-1:0] whole_q, whole_d;
  logic              mute_q;
  out_item_t         res_q, res_d, out_q;
  logic              out_valid_q;

  logic                     div_start, div_done;
  logic [WholeW-1:0]        div_dividend, div_quot;
  logic                     load_res, load_out, out_free;
  logic signed [7:0]        oct_rel, tone_idx;
  logic                     tone_ok;

  rnp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cmd_i.value),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign cfg_ready_o = 1'b1;
  assign cmd_ready_o = (state_q == BK_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign oct_rel  = $signed({4'b0000, cur_q.octave}) - 8'sd4;
  assign tone_idx = (oct_rel <<< 3) + (oct_rel <<< 2) + $signed({4'b0000, cur_q.semitone});
  assign tone_ok  = (cur_q.semitone != 4'd0) && !mute_q && (tone_idx >= 8'sd0)
                    && (tone_idx < 8'sd49);

  always_comb begin
    res_d              = '0;
    res_d.frequency_hz = tone_ok ? tone_lookup(tone_idx[5:0]) : '0;
    res_d.duration_ms  = DurW'(div_quot) + (cur_q.dotted ? DurW'(div_quot >> 1) : '0);
    res_d.last_of_run  = cur_q.last_of_run;
    res_d.tune_end     = cur_q.tune_end;
  end

  always_comb begin
    state_d      = state_q;
    whole_d      = whole_q;
    div_start    = 1'b0;
    div_dividend = whole_q;
    load_res     = 1'b0;
    load_out     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_RESTART: whole_d = WholeReset;
            CMD_TEMPO: begin
              div_start    = 1'b1;
              div_dividend = MsPerMinute;
              state_d      = BK_DIV;
            end
            CMD_NOTE: begin
              div_start = 1'b1;
              state_d   = BK_DIV;
            end
            default: state_d = BK_IDLE;
          endcase
        end
      end
      BK_DIV: begin
        if (div_done) begin
          if (cur_q.kind == CMD_TEMPO) begin
            whole_d = WholeW'({div_quot, 2'b00});
            state_d = BK_IDLE;
          end else begin
            load_res = 1'b1;
            if (cur_q.tune_end) begin
              whole_d = WholeReset;
            end
            state_d = BK_HOLD;
          end
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      whole_q     <= WholeReset;
      mute_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      whole_q <= whole_d;
      if (cfg_valid_i) begin
        mute_q <= cfg_mute_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && cmd_valid_i) begin
      cur_q <= cmd_i;
    end
    if (load_res) begin
      res_q <= res_d;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == BK_DIV)
    else $error("back: divider finished outside of a division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == BK_HOLD |-> cur_q.kind == CMD_NOTE)
    else $error("back: result held for a command that is not a note");

  assert property (@(posedge clk_i) disable iff (!rst_ni) load_out |=> out_valid_q)
    else $error("back: loaded result is not presented");

endmodule

// ===== sv/rtttl_note_parser_top.sv =====
// Top level of the RTTTL note parser: front end, command queue and back end.
// Depends on rnp_pkg, rnp_front, rnp_fifo and rnp_back.
//
//   Channel   Direction   Handshake                  Payload
//   in        input       in_valid_i / in_ready_o    in_item_i (char, end, abort)
//   out       output      out_valid_o / out_ready_i  out_item_o (freq, dur, flags)
//   cfg       input       cfg_valid_i / cfg_ready_o  cfg_mute_i
//
// The front end takes one character per transaction, then pushes each generated
// command (at most two) into a four-entry queue before it takes the next character.
// A note command holds the back end through the 18-step restoring divider and then
// until its result is loaded into the output register; a tempo command holds it
// through the divider only, and a restart command is taken without leaving idle.
// Reset is asynchronous and needs no clearing pass. A stalled output only stops
// the back end; the front end keeps parsing until the queue is full.
module rtttl_note_parser_top #(
  parameter int unsigned DIGIT_WIDTH = rnp_pkg::DigitWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rnp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rnp_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_mute_i
);
  import rnp_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  rnp_front #(
    .DIGIT_WIDTH (DIGIT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  rnp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  rnp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_mute_i  (cfg_mute_i),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== test/rtttl_note_parser_top_tb.sv =====
// Self-checking testbench for rtttl_note_parser_top. It feeds ringtone text one
// character per transaction, predicts every note with a parser model of its own,
// and compares each output transaction. Depends on rnp_pkg and the block's RTL.
module rtttl_note_parser_top_tb;
  import rnp_pkg::*;

  localparam int          CycleLimit    = 1000000;
  localparam int          SettleCycles  = 200;
  localparam int          ItemsPerPhase = 170;
  localparam int          HoldCycles    = 400;
  localparam int unsigned AccMax        = (1 << DigitWidthDef) - 1;
  localparam logic [7:0]  CharP         = 8'h70;
  localparam logic [7:0]  CharEq        = 8'h3D;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_mute_i  = 1'b0;

  rtttl_note_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_mute_i  (cfg_mute_i)
  );

  always #4 clk_i = ~clk_i;

  int          cyc        = 0;
  int          errors     = 0;
  int          pushed     = 0;
  int          taken_n    = 0;
  int          tx_wait    = 0;
  int          rx_wait    = 0;
  int          rx_gap     = 0;
  int          hold_left  = 0;
  logic        hold_req   = 1'b0;
  logic        hold_taken = 1'b0;
  out_item_t   want_tone;
  in_item_t    chars_q [$];
  logic [7:0]  text_q [$];
  out_item_t   tones_due [$];

  int unsigned tone_hz [0:48] = '{
    0, 262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
    523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
    1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
    2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951};

  logic        mute_on = 1'b0;
  phase_e      phase;
  logic [1:0]  skip_n;
  logic [7:0]  len_dflt;
  logic [2:0]  oct_dflt;
  logic [15:0] tempo;
  logic [17:0] whole_ms;
  logic [15:0] num_acc;
  logic [3:0]  nt_semi;
  logic        nt_dot;
  logic [3:0]  nt_oct;
  logic [15:0] nt_div;

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  function automatic void clear_tune();
    phase    = PH_NAME;
    skip_n   = 2'd0;
    len_dflt = 8'd4;
    oct_dflt = 3'd6;
    tempo    = 16'd63;
    whole_ms = WholeReset;
    num_acc  = '0;
    nt_semi  = '0;
    nt_dot   = 1'b0;
    nt_oct   = '0;
    nt_div   = '0;
  endfunction

  function automatic logic [15:0] push_digit(input logic [15:0] v, input logic [7:0] c);
    int unsigned r;
    r = int'(v) * 10 + int'(c) - int'(CharZero);
    return (r > AccMax) ? AccMax[15:0] : r[15:0];
  endfunction

  function automatic void start_note(input logic [7:0] c);
    case (c)
      CharC:   nt_semi = 4'd1;
      CharD:   nt_semi = 4'd3;
      CharE:   nt_semi = 4'd5;
      CharF:   nt_semi = 4'd6;
      CharG:   nt_semi = 4'd8;
      CharA:   nt_semi = 4'd10;
      CharB:   nt_semi = 4'd12;
      default: nt_semi = 4'd0;
    endcase
    nt_div = (num_acc != 0) ? num_acc : {8'd0, len_dflt};
    nt_dot = 1'b0;
    nt_oct = {1'b0, oct_dflt};
    phase  = PH_N_SHARP;
  endfunction

  function automatic void dur_char(input logic [7:0] c);
    if (is_num_char(c)) begin
      num_acc = push_digit(num_acc, c);
      phase   = PH_N_DUR_DIG;
    end else begin
      start_note(c);
    end
  endfunction

  function automatic out_item_t tone_of(input logic fin);
    out_item_t   t;
    int          idx;
    int unsigned d;
    idx = (int'(nt_oct) - 4) * 12 + int'(nt_semi);
    t.frequency_hz = '0;
    if (nt_semi != 0 && !mute_on && idx >= 0 && idx < 49) begin
      t.frequency_hz = FreqW'(tone_hz[idx]);
    end
    d = (nt_div != 0) ? int'(whole_ms) / int'(nt_div) : int'(whole_ms);
    if (nt_dot) d = d + d / 2;
    t.duration_ms = DurW'(d);
    t.last_of_run = 1'b0;
    t.tune_end    = fin;
    return t;
  endfunction

  function automatic void parse_char(input in_item_t it);
    out_item_t  res [2];
    int         n;
    int         i;
    logic [7:0] c;
    logic       taken;
    n     = 0;
    c     = it.char_code;
    taken = 1'b0;
    if (it.abort) begin
      clear_tune();
    end else begin
      case (phase)
        PH_NAME: begin
          if (c == CharColon) phase = PH_KEY_D;
        end
        PH_KEY_D, PH_KEY_O, PH_KEY_B: begin
          if (phase == PH_KEY_D && c == CharD) begin
            phase   = PH_D_VAL;
            skip_n  = 2'd1;
            num_acc = '0;
          end else if (phase != PH_KEY_B && c == CharO) begin
            phase  = PH_O_VAL;
            skip_n = 2'd0;
          end else if (c == CharB) begin
            phase   = PH_B_VAL;
            skip_n  = 2'd1;
            num_acc = '0;
          end else begin
            num_acc = '0;
            phase   = PH_N_DUR;
            dur_char(c);
          end
        end
        PH_D_VAL: begin
          if (skip_n != 0) begin
            skip_n = 2'd0;
          end else if (is_num_char(c)) begin
            num_acc = push_digit(num_acc, c);
          end else begin
            if (num_acc > 0) len_dflt = (num_acc > 255) ? 8'd255 : num_acc[7:0];
            phase = PH_KEY_O;
          end
        end
        PH_O_VAL: begin
          if (skip_n == 0) begin
            skip_n = 2'd1;
          end else if (skip_n == 1) begin
            if (c >= CharThree && c <= CharSeven) oct_dflt = 3'(c - CharZero);
            skip_n = 2'd2;
          end else begin
            skip_n = 2'd0;
            phase  = PH_KEY_B;
          end
        end
        PH_B_VAL: begin
          if (skip_n != 0) begin
            skip_n = 2'd0;
          end else if (is_num_char(c)) begin
            num_acc = push_digit(num_acc, c);
          end else begin
            if (num_acc > 0) tempo = num_acc;
            whole_ms = 18'((60000 / int'(tempo)) * 4);
            num_acc  = '0;
            phase    = PH_N_DUR;
          end
        end
        default: begin
          if (phase == PH_N_DUR || phase == PH_N_DUR_DIG) begin
            dur_char(c);
          end else begin
            if (phase == PH_N_SHARP) begin
              if (c == CharSharp) begin
                nt_semi = nt_semi + 4'd1;
                taken   = 1'b1;
              end
              phase = PH_N_DOT;
            end
            if (!taken && phase == PH_N_DOT) begin
              if (c == CharDot) begin
                nt_dot = 1'b1;
                taken  = 1'b1;
              end
              phase = PH_N_OCT;
            end
            if (!taken && phase == PH_N_OCT) begin
              if (is_num_char(c)) begin
                nt_oct = 4'(c - CharZero);
                taken  = 1'b1;
              end
              phase = PH_N_COMMA;
            end
            if (!taken && phase == PH_N_COMMA && c == CharComma) begin
              phase = PH_N_DONE;
              taken = 1'b1;
            end
            if (!taken) begin
              res[n]  = tone_of(1'b0);
              n++;
              num_acc = '0;
              phase   = PH_N_DUR;
              dur_char(c);
            end
          end
        end
      endcase
      if (it.end_of_text) begin
        if (phase == PH_N_DUR_DIG) begin
          start_note(8'd0);
          phase = PH_N_DONE;
        end
        if (phase >= PH_N_SHARP) begin
          res[n] = tone_of(1'b1);
          n++;
        end
        clear_tune();
      end
      if (n > 0) res[n-1].last_of_run = 1'b1;
      for (i = 0; i < n; i++) tones_due.push_back(res[i]);
    end
  endfunction

  function automatic int idle_len();
    int r;
    if (cyc % 2048 < 400) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void queue_item(input logic [7:0] c, input logic eot, input logic stop);
    in_item_t it;
    it.char_code   = c;
    it.end_of_text = eot;
    it.abort       = stop;
    chars_q.push_back(it);
    pushed++;
  endfunction

  function automatic void add_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_num(input int unsigned v);
    logic [7:0] d [$];
    do begin
      d.push_front(CharZero + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (d[i]) text_q.push_back(d[i]);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 6) return 1 << r;
    if (r == 6) return 0;
    if (r == 7) return $urandom_range(33, 999);
    if (r == 8) return $urandom_range(65536, 999999);
    return 1 << $urandom_range(0, 5);
  endfunction

  function automatic int unsigned pick_tempo();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 1;
    if (r == 2) return 65535;
    if (r == 3) return $urandom_range(65536, 999999);
    return $urandom_range(25, 900);
  endfunction

  function automatic logic [7:0] octave_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CharThree + 8'($urandom_range(0, 4));
    if (r < 95) return CharZero + 8'($urandom_range(0, 9));
    return any_byte();
  endfunction

  function automatic logic [7:0] pick_letter();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 19);
    if (r >= 16) begin
      c = any_byte();
      if (is_num_char(c)) c = c + 8'd10;
      return c;
    end
    case (r % 8)
      0:       c = CharA;
      1:       c = CharB;
      2:       c = CharC;
      3:       c = CharD;
      4:       c = CharE;
      5:       c = CharF;
      6:       c = CharG;
      default: c = CharP;
    endcase
    return c;
  endfunction

  // A noisy text may get one stray character and may be cut short by an abort.
  function automatic void send_text(input logic noisy);
    int junk_at;
    int cut_at;
    int last;
    int i;
    junk_at = -1;
    cut_at  = -1;
    last    = text_q.size() - 1;
    if (noisy && $urandom_range(0, 99) < 20) junk_at = $urandom_range(0, last);
    if (noisy && $urandom_range(0, 99) < 6) cut_at = $urandom_range(0, last);
    for (i = 0; i <= last; i++) begin
      if (i == cut_at) begin
        queue_item(any_byte(), 1'($urandom_range(0, 1)), 1'b1);
        break;
      end
      if (i == junk_at) queue_item(any_byte(), 1'b0, 1'b0);
      queue_item(text_q[i], i == last, 1'b0);
    end
    text_q.delete();
  endfunction

  function automatic void add_tune();
    int n;
    int i;
    text_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(any_byte());
    end else begin
      repeat ($urandom_range(0, 3)) begin
        text_q.push_back(($urandom_range(0, 9) == 0) ? any_byte() :
                         8'($urandom_range(8'h61, 8'h7A)));
      end
      text_q.push_back(CharColon);
      if ($urandom_range(0, 99) < 80) begin
        text_q.push_back(CharD);
        text_q.push_back(CharEq);
        put_num(pick_length());
        text_q.push_back(CharComma);
      end
      if ($urandom_range(0, 99) < 80) begin
        text_q.push_back(CharO);
        text_q.push_back(CharEq);
        text_q.push_back(octave_char());
        text_q.push_back(CharComma);
      end
      if ($urandom_range(0, 99) < 90) begin
        text_q.push_back(CharB);
        text_q.push_back(CharEq);
        put_num(pick_tempo());
      end
      text_q.push_back(CharColon);
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) put_num(pick_length());
        text_q.push_back(pick_letter());
        if ($urandom_range(0, 99) < 30) text_q.push_back(CharSharp);
        if ($urandom_range(0, 99) < 25) text_q.push_back(CharDot);
        if ($urandom_range(0, 99) < 50) text_q.push_back(octave_char());
        if (i < n - 1 || $urandom_range(0, 99) < 30) text_q.push_back(CharComma);
      end
      if ($urandom_range(0, 99) < 15) put_num(pick_length());
    end
    send_text(1'b1);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic settle();
    while (taken_n != pushed || tones_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mute(input logic v);
    cfg_mute_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mute_on = v;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_wait    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_char(in_item_i);
        taken_n++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_wait > 0) begin
          tx_wait    <= tx_wait - 1;
          in_valid_i <= 1'b0;
        end else if (chars_q.size() > 0) begin
          in_item_i  <= chars_q.pop_front();
          in_valid_i <= 1'b1;
          tx_wait    <= idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else begin
      rx_gap = 0;
      if (out_valid_o && out_ready_i) begin
        rx_gap = idle_len();
        if (tones_due.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0d Hz %0d ms %0b %0b",
                   $time, out_item_o.frequency_hz, out_item_o.duration_ms,
                   out_item_o.last_of_run, out_item_o.tune_end);
          errors++;
        end else begin
          want_tone = tones_due.pop_front();
          check_field("frequency_hz", 32'(want_tone.frequency_hz),
                      32'(out_item_o.frequency_hz));
          check_field("duration_ms", 32'(want_tone.duration_ms),
                      32'(out_item_o.duration_ms));
          check_field("last_of_run", 32'(want_tone.last_of_run),
                      32'(out_item_o.last_of_run));
          check_field("tune_end", 32'(want_tone.tune_end), 32'(out_item_o.tune_end));
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken  <= 1'b1;
        hold_left   <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait     <= rx_wait - 1;
        out_ready_i <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_wait     <= rx_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int phase_no;
    int goal;
    clear_tune();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_mute(1'b0);

    text_q.push_back(8'hFF);
    add_string(":b=0:p#.9,b");
    send_text(1'b0);
    text_q.push_back(8'h00);
    add_string(":d=70000,o=2,32");
    send_text(1'b0);
    add_string(":d");
    send_text(1'b0);
    queue_item(CharO, 1'b1, 1'b1);
    settle();

    for (phase_no = 0; phase_no < 4; phase_no++) begin
      write_mute(phase_no % 2 == 0);
      if (phase_no == 1) hold_req <= 1'b1;
      goal = pushed + ItemsPerPhase;
      while (pushed < goal) add_tune();
      settle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
